[rtl/fifo_negative_lookup_cache_defines.svh]
// Assertion macros shared by the negative lookup cache RTL.
`ifndef FIFO_NEGATIVE_LOOKUP_CACHE_DEFINES_SVH
`define FIFO_NEGATIVE_LOOKUP_CACHE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FNLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FNLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fnlc_pkg.sv]
// Shared constants for the negative lookup cache.
`timescale 1ns / 1ps
package fnlc_pkg;

  localparam int DEPTH_DEF = 512;
  localparam int CMD_W     = 2;
  localparam int KEY_W     = 21;
  localparam int FILL_W    = 10;

  // Command codes carried on in_command
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

endpackage

[rtl/fifo_negative_lookup_cache.sv]
// Negative lookup cache: ring of keys in one synchronous memory, scanned per lookup.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------
//   in      | sink      | in_valid, in_ready, in_command, in_key
//   out     | source    | out_valid, out_ready, out_found, out_fill_count
//
// Insert, clear, an unused command and a lookup on an empty ring give their
// beat on the cycle after acceptance. A lookup reads the entry memory one
// entry per cycle through its single read port, so its beat comes once every
// stored entry has been compared, earlier on a hit.
// Reset (rst_n low, synchronous) empties the ring at once; no clearing pass.
// A new beat is taken only when the sequencer is idle and the result register
// is free or being drained in the same cycle.
`timescale 1ns / 1ps
`include "fifo_negative_lookup_cache_defines.svh"

module fifo_negative_lookup_cache #(
  parameter int DEPTH = fnlc_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fnlc_pkg::CMD_W-1:0]  in_command,
  input  logic [fnlc_pkg::KEY_W-1:0]  in_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [fnlc_pkg::FILL_W-1:0] out_fill_count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Entry memory, undefined until written
  logic [fnlc_pkg::KEY_W-1:0] mem [DEPTH];

  state_t                     state_r,    state_nxt;
  logic [PTR_W-1:0]           wp_r,       wp_nxt;
  logic [CNT_W-1:0]           cnt_r,      cnt_nxt;
  logic [CNT_W-1:0]           iss_cnt_r,  iss_cnt_nxt;
  logic                       data_v_r,   data_v_nxt;
  logic [fnlc_pkg::KEY_W-1:0] key_r,      key_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [CNT_W-1:0]           out_cnt_r,  out_cnt_nxt;
  logic [fnlc_pkg::KEY_W-1:0] rd_data_r;

  logic in_fire;
  logic issue;
  logic hit;
  logic do_write;
  logic [CNT_W+fnlc_pkg::FILL_W-1:0] fill_ext;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign issue    = (state_r == ST_SCAN) && (iss_cnt_r != cnt_r);
  assign hit      = data_v_r && (rd_data_r == key_r);
  assign do_write = in_fire && (in_command == fnlc_pkg::CMD_INSERT);

  // Sequencer: command decode, scan control and result register
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    iss_cnt_nxt   = iss_cnt_r;
    data_v_nxt    = 1'b0;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_cnt_nxt   = out_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_found_nxt = 1'b0;
          unique case (in_command)
            fnlc_pkg::CMD_LOOKUP: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_cnt_nxt   = cnt_r;
              end else begin
                key_nxt     = in_key;
                iss_cnt_nxt = '0;
                state_nxt   = ST_SCAN;
              end
            end
            fnlc_pkg::CMD_INSERT: begin
              wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
              if (cnt_r != CNT_FULL) begin
                cnt_nxt = cnt_r + 1'b1;
              end
              out_valid_nxt = 1'b1;
              out_cnt_nxt   = (cnt_r != CNT_FULL) ? cnt_r + 1'b1 : cnt_r;
            end
            fnlc_pkg::CMD_CLEAR: begin
              wp_nxt        = '0;
              cnt_nxt       = '0;
              out_valid_nxt = 1'b1;
              out_cnt_nxt   = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_cnt_nxt   = cnt_r;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Stop on a hit, or once every issued read has been compared
        if (hit || (!data_v_r && !issue)) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_found_nxt = hit;
          out_cnt_nxt   = cnt_r;
        end else if (issue) begin
          iss_cnt_nxt = iss_cnt_r + 1'b1;
          data_v_nxt  = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      cnt_r       <= '0;
      iss_cnt_r   <= '0;
      data_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      data_v_r    <= data_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r       <= key_nxt;
    out_found_r <= out_found_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  // Entry memory: write on insert, registered read during the scan
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wp_r] <= in_key;
    end
    if (issue) begin
      rd_data_r <= mem[iss_cnt_r[PTR_W-1:0]];
    end
  end

  // Report the low bits of the count
  assign fill_ext       = {{fnlc_pkg::FILL_W{1'b0}}, out_cnt_r};
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_fill_count = fill_ext[fnlc_pkg::FILL_W-1:0];

  `FNLC_ASSERT_NOW(a_cnt_bounded, clk, rst_n, 1'b1, cnt_r <= CNT_FULL, "count above depth")
  `FNLC_ASSERT_NOW(a_scan_within_fill, clk, rst_n,
                   state_r == ST_SCAN, iss_cnt_r <= cnt_r, "scan past fill")
  `FNLC_ASSERT_NOW(a_no_result_in_scan, clk, rst_n,
                   state_r == ST_SCAN, !out_valid_r, "result pending in scan")
  `FNLC_ASSERT_NEXT(a_insert_grows, clk, rst_n,
                    do_write && (cnt_r != CNT_FULL),
                    cnt_r == CNT_W'($past(cnt_r) + 1'b1), "insert did not grow count")

endmodule
